@@ src/ntae_pkg.sv @@
`default_nettype none
package ntae_pkg;

    localparam int unsigned ENTRIES_DEF = 16;

    localparam logic [2:0] ST_EMPTY = 3'd0;
    localparam logic [2:0] ST_NEW   = 3'd1;
    localparam logic [2:0] ST_VALID = 3'd2;
    localparam logic [2:0] ST_GUARD = 3'd3;
    localparam logic [2:0] ST_OLD   = 3'd4;

    localparam logic [1:0] K_TICK  = 2'd0;
    localparam logic [1:0] K_FIND  = 2'd1;
    localparam logic [1:0] K_ALLOC = 2'd2;
    localparam logic [1:0] K_WRITE = 2'd3;

    localparam logic [2:0] R_HIT      = 3'd0;
    localparam logic [2:0] R_NOTFOUND = 3'd1;
    localparam logic [2:0] R_ALLOC    = 3'd2;
    localparam logic [2:0] R_FULL     = 3'd3;
    localparam logic [2:0] R_WRITTEN  = 3'd4;
    localparam logic [2:0] R_PROMOTED = 3'd5;
    localparam logic [2:0] R_SUMMARY  = 3'd6;

    localparam logic [2:0] CFG_TICK    = 3'd0;
    localparam logic [2:0] CFG_UNREACH = 3'd1;
    localparam logic [2:0] CFG_REACH   = 3'd2;
    localparam logic [2:0] CFG_NEW_TO  = 3'd3;
    localparam logic [2:0] CFG_VAL_TO  = 3'd4;
    localparam logic [2:0] CFG_GRD_TO  = 3'd5;

    // entry word: state, id, timeout, unreachable time
    localparam int unsigned ENTRY_W = 3 + 32 + 32 + 32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] node_id;
        logic [3:0]  slot;
        logic [2:0]  set_state;
        logic        clear_unreach;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  result_slot;
        logic [31:0] result_id;
        logic [2:0]  reachable_count;
        logic [31:0] led_pattern;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] id;
        logic [31:0] tmo;
        logic [31:0] unr;
    } t_entry;

    typedef struct packed {
        logic [15:0] tick_ms;
        logic [31:0] unreach_lim;
        logic [31:0] reach_lim;
        logic [31:0] new_to;
        logic [31:0] valid_to;
        logic [31:0] guard_to;
    } t_cfg;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_PROC, S_EMIT, S_DONE
    } t_fsm;

    function automatic logic [31:0] led_of(input logic [2:0] c);
        logic [31:0] r;
        begin
            case (c)
                3'd0: r = 32'h0;
                3'd1: r = 32'hf1;
                3'd2: r = 32'hf111;
                3'd3: r = 32'hf11111;
                3'd4: r = 32'hf1111111;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] timeout_of(input logic [2:0] s, input t_cfg c);
        logic [31:0] r;
        begin
            case (s)
                ST_NEW:   r = c.new_to;
                ST_VALID: r = c.valid_to;
                ST_GUARD: r = c.guard_to;
                default:  r = 32'hffff_ffff;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/ntae_ram.sv @@
`default_nettype none
module ntae_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/ntae_age.sv @@
`default_nettype none
// Combinational aging of one entry as a tick visits it.
module ntae_age (
    input  wire ntae_pkg::t_entry i_e,
    input  wire ntae_pkg::t_cfg   i_cfg,
    output ntae_pkg::t_entry      o_e,
    output logic                  o_promote
);
    ntae_pkg::t_entry a;
    ntae_pkg::t_entry b;
    ntae_pkg::t_entry c;
    logic [32:0]      sum;
    logic [31:0]      tk;

    always_comb begin
        tk = {16'd0, i_cfg.tick_ms};
        a = i_e;
        if (i_e.unr >= i_cfg.unreach_lim &&
            (i_e.st == ntae_pkg::ST_NEW || i_e.st == ntae_pkg::ST_VALID ||
             i_e.st == ntae_pkg::ST_GUARD)) begin
            a.st  = ntae_pkg::ST_OLD;
            a.tmo = 32'hffff_ffff;
        end
        b = a;
        if (a.tmo == 32'd0) begin
            case (a.st)
                ntae_pkg::ST_NEW:   b.st = ntae_pkg::ST_GUARD;
                ntae_pkg::ST_VALID: b.st = ntae_pkg::ST_NEW;
                ntae_pkg::ST_GUARD: b.st = ntae_pkg::ST_OLD;
                default:            b.st = a.st;
            endcase
            if (b.st != a.st) begin
                b.tmo = ntae_pkg::timeout_of(b.st, i_cfg);
            end
        end
        c = b;
        o_promote = 1'b0;
        if (b.st == ntae_pkg::ST_NEW) begin
            c.st = ntae_pkg::ST_VALID;
            c.tmo = i_cfg.valid_to;
            o_promote = 1'b1;
        end else if (b.st == ntae_pkg::ST_OLD) begin
            c = '0;
        end
        o_e = c;
        sum = {1'b0, c.unr} + {1'b0, tk};
        if (c.st != ntae_pkg::ST_EMPTY) begin
            o_e.tmo = (c.tmo >= tk) ? c.tmo - tk : 32'd0;
            o_e.unr = sum[32] ? 32'hffff_ffff : sum[31:0];
        end
    end
endmodule
`default_nettype wire

@@ src/neighbor_table_aging_engine_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake                    Payload
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
// request   in         i_in_valid / o_in_ready      i_in (ntae_pkg::t_in)
// result    out        o_out_valid / i_out_ready    o_out (ntae_pkg::t_out)
//
// After reset a clearing pass writes ENTRIES rows, one per cycle, before the
// first request is taken. A write reads its row, writes it back, then emits.
// A tick visits every row (read, then update/write back), emitting a result
// after each promotion. Find and allocate stop at the first match; a match
// at row k below the last reads that row twice. Each result waits in the
// output register until taken; a further result stalls the sweep meanwhile.
module neighbor_table_aging_engine_unit #(
    parameter int unsigned ENTRIES = ntae_pkg::ENTRIES_DEF,
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ntae_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ntae_pkg::t_out     o_out
);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    ntae_pkg::t_fsm   r_fsm, n_fsm;
    ntae_pkg::t_cfg   r_cfg;
    ntae_pkg::t_in    r_req;
    logic [AW-1:0]    r_idx;
    logic [2:0]       r_cnt;
    logic             r_found;
    ntae_pkg::t_out   r_pend;
    ntae_pkg::t_out   r_out;
    logic             r_out_valid;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [ntae_pkg::ENTRY_W-1:0] wdata, rdata;
    ntae_pkg::t_entry ent, aged, wr_e;
    logic             promote;
    logic             done_row;
    logic             slot_ok;
    logic             emit;
    ntae_pkg::t_out   emit_val;

    ntae_ram #(.WIDTH(ntae_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    ntae_age u_age (.i_e(ent), .i_cfg(r_cfg), .o_e(aged), .o_promote(promote));

    assign ent = ntae_pkg::t_entry'(rdata);
    assign slot_ok = (32'(r_req.slot) < ENTRIES);
    assign done_row = (r_idx == LAST_IDX);
    assign o_in_ready = (r_fsm == ntae_pkg::S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_comb begin
        wr_e = ent;
        wr_e.id = r_req.node_id;
        if (r_req.set_state <= ntae_pkg::ST_OLD) begin
            wr_e.st = r_req.set_state;
            if (r_req.set_state != ntae_pkg::ST_EMPTY) begin
                wr_e.tmo = ntae_pkg::timeout_of(r_req.set_state, r_cfg);
            end
        end
        if (r_req.clear_unreach) begin
            wr_e.unr = 32'd0;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            ntae_pkg::S_CLEAR: if (done_row) n_fsm = ntae_pkg::S_IDLE;
            ntae_pkg::S_IDLE:  if (i_in_valid && o_in_ready) n_fsm = ntae_pkg::S_READ;
            ntae_pkg::S_READ:  n_fsm = ntae_pkg::S_PROC;
            ntae_pkg::S_PROC: begin
                if (r_req.kind == ntae_pkg::K_WRITE) n_fsm = ntae_pkg::S_DONE;
                else if (r_req.kind == ntae_pkg::K_TICK && promote) n_fsm = ntae_pkg::S_EMIT;
                else if (done_row || r_found) n_fsm = ntae_pkg::S_DONE;
                else n_fsm = ntae_pkg::S_READ;
            end
            ntae_pkg::S_EMIT: begin
                if (!r_out_valid) n_fsm = done_row ? ntae_pkg::S_DONE : ntae_pkg::S_READ;
            end
            ntae_pkg::S_DONE:  if (!r_out_valid) n_fsm = ntae_pkg::S_IDLE;
            default:           n_fsm = ntae_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = '0;
        raddr = r_idx;
        emit = 1'b0;
        emit_val = r_pend;
        case (r_fsm)
            ntae_pkg::S_CLEAR: we = 1'b1;
            ntae_pkg::S_PROC: begin
                if (r_req.kind == ntae_pkg::K_TICK) begin
                    we = 1'b1;
                    wdata = aged;
                end else if (r_req.kind == ntae_pkg::K_WRITE) begin
                    we = slot_ok;
                    wdata = wr_e;
                end
            end
            ntae_pkg::S_EMIT, ntae_pkg::S_DONE: begin
                emit = !r_out_valid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ntae_pkg::S_CLEAR;
            r_idx <= '0;
            r_out_valid <= 1'b0;
            r_cfg.tick_ms <= 16'd100;
            r_cfg.unreach_lim <= 32'd60000;
            r_cfg.reach_lim <= 32'd10000;
            r_cfg.new_to <= 32'd5000;
            r_cfg.valid_to <= 32'd600000;
            r_cfg.guard_to <= 32'd30000;
            r_cnt <= '0;
            r_found <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ntae_pkg::CFG_TICK:    r_cfg.tick_ms <= i_cfg_data[15:0];
                    ntae_pkg::CFG_UNREACH: r_cfg.unreach_lim <= i_cfg_data;
                    ntae_pkg::CFG_REACH:   r_cfg.reach_lim <= i_cfg_data;
                    ntae_pkg::CFG_NEW_TO:  r_cfg.new_to <= i_cfg_data;
                    ntae_pkg::CFG_VAL_TO:  r_cfg.valid_to <= i_cfg_data;
                    ntae_pkg::CFG_GRD_TO:  r_cfg.guard_to <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out <= emit_val;
            end
            case (r_fsm)
                ntae_pkg::S_CLEAR: if (!done_row) r_idx <= r_idx + 1'b1;
                ntae_pkg::S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_req <= i_in;
                        r_cnt <= '0;
                        r_found <= 1'b0;
                        r_idx <= (i_in.kind == ntae_pkg::K_WRITE) ? AW'(i_in.slot) : '0;
                    end
                end
                ntae_pkg::S_PROC: begin
                    case (r_req.kind)
                        ntae_pkg::K_TICK: begin
                            if (aged.st == ntae_pkg::ST_VALID && aged.unr < r_cfg.reach_lim
                                && r_cnt < 3'd4) r_cnt <= r_cnt + 3'd1;
                            if (promote) begin
                                r_pend <= '{ntae_pkg::R_PROMOTED, 4'(r_idx), ent.id,
                                            3'd0, 32'd0, 1'b0};
                            end else if (!done_row) r_idx <= r_idx + 1'b1;
                        end
                        ntae_pkg::K_FIND: begin
                            if (ent.st != ntae_pkg::ST_EMPTY && ent.id == r_req.node_id) begin
                                r_found <= 1'b1;
                                r_pend <= '{ntae_pkg::R_HIT, 4'(r_idx), ent.id,
                                            3'd0, 32'd0, 1'b1};
                            end else begin
                                r_pend <= '{ntae_pkg::R_NOTFOUND, 4'd0, 32'd0,
                                            3'd0, 32'd0, 1'b1};
                                if (!done_row) r_idx <= r_idx + 1'b1;
                            end
                        end
                        ntae_pkg::K_ALLOC: begin
                            if (ent.st == ntae_pkg::ST_EMPTY) begin
                                r_found <= 1'b1;
                                r_pend <= '{ntae_pkg::R_ALLOC, 4'(r_idx), 32'd0,
                                            3'd0, 32'd0, 1'b1};
                            end else begin
                                r_pend <= '{ntae_pkg::R_FULL, 4'd0, 32'd0,
                                            3'd0, 32'd0, 1'b1};
                                if (!done_row) r_idx <= r_idx + 1'b1;
                            end
                        end
                        default: begin
                            r_pend <= '{ntae_pkg::R_WRITTEN, r_req.slot, 32'd0,
                                        3'd0, 32'd0, 1'b1};
                        end
                    endcase
                end
                ntae_pkg::S_EMIT: begin
                    if (!r_out_valid) begin
                        if (!done_row) r_idx <= r_idx + 1'b1;
                        else r_pend <= '{ntae_pkg::R_SUMMARY, 4'd0, 32'd0, r_cnt,
                                         ntae_pkg::led_of(r_cnt), 1'b1};
                    end
                end
                default: ;
            endcase
            // summary built once the last row is processed without a promotion
            if (r_fsm == ntae_pkg::S_PROC && r_req.kind == ntae_pkg::K_TICK && !promote
                && done_row) begin
                r_pend <= '{ntae_pkg::R_SUMMARY, 4'd0, 32'd0,
                            ((aged.st == ntae_pkg::ST_VALID && aged.unr < r_cfg.reach_lim
                              && r_cnt < 3'd4) ? r_cnt + 3'd1 : r_cnt),
                            ntae_pkg::led_of((aged.st == ntae_pkg::ST_VALID
                              && aged.unr < r_cfg.reach_lim && r_cnt < 3'd4)
                              ? r_cnt + 3'd1 : r_cnt), 1'b1};
            end
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != ntae_pkg::S_IDLE) |-> !o_in_ready)
        else $error("request taken while busy");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("reachable count above cap");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !r_out_valid)
        else $error("result overwritten");
`endif
endmodule
`default_nettype wire

@@ tb/neighbor_table_aging_engine_unit_test.sv @@
module neighbor_table_aging_engine_unit_test;
    import ntae_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    t_in i_in = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid;
    t_out o_out;

    neighbor_table_aging_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow table and registers
    logic [2:0]  tbl_state [NSLOT];
    logic [31:0] tbl_id [NSLOT];
    logic [31:0] tbl_tmo [NSLOT];
    logic [31:0] tbl_unr [NSLOT];
    t_cfg shadow_cfg;

    t_in  req_queue[$];
    t_out want_results[$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   in_taken = 1'b0;
    logic [31:0] id_pool [6] = '{32'h0, 32'hffff_ffff, 32'h1234_5678, 32'h8000_0001,
                                 32'h5a5a_a5a5, 32'h0000_00ff};

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [31:0] led_word(input int n);
        case (n)
            1: return 32'hf1;
            2: return 32'hf111;
            3: return 32'hf11111;
            4: return 32'hf1111111;
            default: return 32'h0;
        endcase
    endfunction

    function automatic t_out result_of(input logic [2:0] k, input logic [3:0] s,
                                       input logic [31:0] id, input logic [2:0] n,
                                       input logic [31:0] led, input logic lst);
        t_out r;
        r.result_kind = k; r.result_slot = s; r.result_id = id;
        r.reachable_count = n; r.led_pattern = led; r.last = lst;
        return r;
    endfunction

    // load state and its timeout (none for ST_EMPTY); undefined codes leave both alone
    function automatic void set_entry_state(input int i, input logic [2:0] st);
        case (st)
            ST_EMPTY: ;
            ST_NEW:   tbl_tmo[i] = shadow_cfg.new_to;
            ST_VALID: tbl_tmo[i] = shadow_cfg.valid_to;
            ST_GUARD: tbl_tmo[i] = shadow_cfg.guard_to;
            ST_OLD:   tbl_tmo[i] = 32'hffff_ffff;
            default:  return;
        endcase
        tbl_state[i] = st;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = ST_EMPTY; tbl_id[i] = '0; tbl_tmo[i] = '0; tbl_unr[i] = '0;
        end
        shadow_cfg = '{tick_ms: 16'd100, unreach_lim: 32'd60000, reach_lim: 32'd10000,
                       new_to: 32'd5000, valid_to: 32'd600000, guard_to: 32'd30000};
    endfunction

    function automatic void age_table_predict(input t_in x);
        int n;
        logic [32:0] sum;
        bit done;
        n = 0;
        done = 0;
        case (x.kind)
            K_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_unr[i] >= shadow_cfg.unreach_lim && (tbl_state[i] == ST_NEW ||
                        tbl_state[i] == ST_VALID || tbl_state[i] == ST_GUARD))
                        set_entry_state(i, ST_OLD);
                    if (tbl_tmo[i] == 0) begin
                        if (tbl_state[i] == ST_NEW) set_entry_state(i, ST_GUARD);
                        else if (tbl_state[i] == ST_VALID) set_entry_state(i, ST_NEW);
                        else if (tbl_state[i] == ST_GUARD) set_entry_state(i, ST_OLD);
                    end
                    if (tbl_state[i] == ST_NEW) begin
                        set_entry_state(i, ST_VALID);
                        want_results.push_back(result_of(R_PROMOTED, i, tbl_id[i], 0, 0, 0));
                    end else if (tbl_state[i] == ST_OLD) begin
                        tbl_state[i] = ST_EMPTY; tbl_id[i] = '0; tbl_tmo[i] = '0;
                        tbl_unr[i] = '0;
                    end
                    if (tbl_state[i] != ST_EMPTY) begin
                        tbl_tmo[i] = (tbl_tmo[i] >= shadow_cfg.tick_ms) ?
                                     tbl_tmo[i] - shadow_cfg.tick_ms : 32'd0;
                        sum = {1'b0, tbl_unr[i]} + shadow_cfg.tick_ms;
                        tbl_unr[i] = sum[32] ? 32'hffff_ffff : sum[31:0];
                    end
                end
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_state[i] == ST_VALID && tbl_unr[i] < shadow_cfg.reach_lim && n < 4)
                        n++;
                want_results.push_back(result_of(R_SUMMARY, 0, 0, n, led_word(n), 1));
            end
            K_FIND: begin
                for (int i = 0; i < NSLOT && !done; i++)
                    if (tbl_state[i] != ST_EMPTY && tbl_id[i] == x.node_id) begin
                        want_results.push_back(result_of(R_HIT, i, tbl_id[i], 0, 0, 1));
                        done = 1;
                    end
                if (!done) want_results.push_back(result_of(R_NOTFOUND, 0, 0, 0, 0, 1));
            end
            K_ALLOC: begin
                for (int i = 0; i < NSLOT && !done; i++)
                    if (tbl_state[i] == ST_EMPTY) begin
                        want_results.push_back(result_of(R_ALLOC, i, 0, 0, 0, 1));
                        done = 1;
                    end
                if (!done) want_results.push_back(result_of(R_FULL, 0, 0, 0, 0, 1));
            end
            default: begin
                tbl_id[x.slot] = x.node_id;
                set_entry_state(x.slot, x.set_state);
                if (x.clear_unreach) tbl_unr[x.slot] = '0;
                want_results.push_back(result_of(R_WRITTEN, x.slot, 0, 0, 0, 1));
            end
        endcase
    endfunction

    function automatic t_in make_req(input logic [1:0] k, input logic [31:0] id,
                                     input logic [3:0] s, input logic [2:0] st,
                                     input logic clr);
        t_in r;
        r.kind = k; r.node_id = id; r.slot = s; r.set_state = st; r.clear_unreach = clr;
        return r;
    endfunction

    function automatic t_in random_req();
        int pick;
        logic [31:0] id;
        logic [2:0] st;
        pick = $urandom_range(99);
        id = ($urandom_range(3) != 0) ? id_pool[$urandom_range(5)] : $urandom;
        st = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
        if (pick < 30) return make_req(K_TICK, $urandom, $urandom, $urandom, $urandom);
        if (pick < 55) return make_req(K_FIND, id, $urandom, $urandom, $urandom);
        if (pick < 68) return make_req(K_ALLOC, $urandom, $urandom, $urandom, $urandom);
        return make_req(K_WRITE, id, $urandom, st, $urandom);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TICK:    shadow_cfg.tick_ms = val[15:0];
            CFG_UNREACH: shadow_cfg.unreach_lim = val;
            CFG_REACH:   shadow_cfg.reach_lim = val;
            CFG_NEW_TO:  shadow_cfg.new_to = val;
            CFG_VAL_TO:  shadow_cfg.valid_to = val;
            default:     shadow_cfg.guard_to = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_regs(input logic [31:0] tk, input logic [31:0] ul,
                              input logic [31:0] rl, input logic [31:0] nt,
                              input logic [31:0] vt, input logic [31:0] gt);
        write_reg(CFG_TICK, tk);
        write_reg(CFG_UNREACH, ul);
        write_reg(CFG_REACH, rl);
        write_reg(CFG_NEW_TO, nt);
        write_reg(CFG_VAL_TO, vt);
        write_reg(CFG_GRD_TO, gt);
    endtask

    task automatic wait_quiet();
        @(posedge i_clk);
        while (req_queue.size() != 0 || i_in_valid || want_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // driver: present a new transaction only once the previous one was taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= req_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: check results, then record the accepted request
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (want_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_out));
            end else begin
                t_out w;
                w = want_results.pop_front();
                if (o_out.result_kind !== w.result_kind)
                    report_mismatch($sformatf("kind %0d want %0d", o_out.result_kind,
                                              w.result_kind));
                if (o_out.result_slot !== w.result_slot)
                    report_mismatch($sformatf("slot %0d want %0d", o_out.result_slot,
                                              w.result_slot));
                if (o_out.result_id !== w.result_id)
                    report_mismatch($sformatf("id %h want %h", o_out.result_id, w.result_id));
                if (o_out.reachable_count !== w.reachable_count)
                    report_mismatch($sformatf("count %0d want %0d", o_out.reachable_count,
                                              w.reachable_count));
                if (o_out.led_pattern !== w.led_pattern)
                    report_mismatch($sformatf("led %h want %h", o_out.led_pattern,
                                              w.led_pattern));
                if (o_out.last !== w.last)
                    report_mismatch($sformatf("last %b want %b", o_out.last, w.last));
            end
        end
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_taken) age_table_predict(i_in);
    end

    initial begin
        reset_table();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every slot with a live entry, then hit the corner operations
        for (int i = 0; i < NSLOT; i++)
            req_queue.push_back(make_req(K_WRITE,
                (i == 0) ? 32'h0 : (i == 15) ? 32'hffff_ffff : $urandom,
                i, 3'(i % 4 + 1), i[0]));
        req_queue.push_back(make_req(K_ALLOC, 0, 0, 0, 0));
        req_queue.push_back(make_req(K_FIND, 32'h0, 0, 0, 0));
        req_queue.push_back(make_req(K_FIND, 32'hdead_beef, 0, 0, 0));
        req_queue.push_back(make_req(K_WRITE, 32'h1111_2222, 4'd3, 3'd7, 1'b1));
        req_queue.push_back(make_req(K_WRITE, 32'h3333_4444, 4'd5, ST_EMPTY, 1'b0));
        req_queue.push_back(make_req(K_ALLOC, 0, 0, 0, 0));
        req_queue.push_back(make_req(K_TICK, 0, 0, 0, 0));
        req_queue.push_back(make_req(K_TICK, 0, 0, 0, 0));
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_regs(100, 2000, 700, 300, 800, 500);
                1: write_regs(1, 32'hffff_ffff, 32'hffff_ffff, 3, 5, 2);
                2: write_regs(65535, 0, 0, 0, 0, 0);
                3: write_regs(0, 1000, 500, 0, 0, 0);
                4: write_regs(250, 1500, 1000, 0, 32'hffff_ffff, 400);
                default: write_regs(100, 60000, 10000, 5000, 600000, 30000);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 65; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 65; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < 24; n++) req_queue.push_back(random_req());
            wait_quiet();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/ntae_pkg.sv
src/ntae_ram.sv
src/ntae_age.sv
src/neighbor_table_aging_engine_unit.sv
tb/neighbor_table_aging_engine_unit_test.sv
